>>> rtl/tsgr_pkg.sv
// shared types and constants for the two-stop gradient ramp
package tsgr_pkg;

	localparam int unsigned RAMP_LENGTH  = 44;
	localparam int unsigned SLIDER_RANGE = 168;

	localparam int unsigned COLOR_W    = 24;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned OPAC_W     = 7;
	localparam int unsigned SLIDER_W   = 8;
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [OPAC_W-1:0] OPACITY_FULL = OPAC_W'(100);

	// mapped stop position range and reciprocal for the slider mapping
	localparam int unsigned POS_MAX   = ((2**SLIDER_W - 1) * RAMP_LENGTH) / SLIDER_RANGE;
	localparam int unsigned POS_W     = $clog2(POS_MAX + 1);
	localparam int unsigned MAP_N_W   = $clog2((2**SLIDER_W - 1) * RAMP_LENGTH + 1);
	localparam int unsigned MAP_SHIFT = MAP_N_W + SLIDER_W;
	localparam int unsigned MAP_MUL   = (2**MAP_SHIFT + SLIDER_RANGE - 1) / SLIDER_RANGE;

	// blend numerator and reciprocal of one hundred
	localparam int unsigned BLEND_W      = 15;
	localparam int unsigned DIV100_SHIFT = 22;
	localparam int unsigned DIV100_MUL   = (2**DIV100_SHIFT + 99) / 100;

	// interpolation numerator, divided radix 4 over the quotient bits
	localparam int unsigned INTERP_W  = CHAN_W + POS_W;
	localparam int unsigned DIV_STEPS = CHAN_W / 2;

	localparam logic [CFG_IDX_W-1:0] REG_START_COLOR    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_END_COLOR      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_START_OPACITY  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_END_OPACITY    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_START_SLIDER   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_END_SLIDER     = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_BACKDROP = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_DARK_BACKDROP  = CFG_IDX_W'(7);

	localparam logic [COLOR_W-1:0]  RST_START_COLOR    = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0]  RST_END_COLOR      = 24'h000000;
	localparam logic [OPAC_W-1:0]   RST_START_OPACITY  = OPAC_W'(100);
	localparam logic [OPAC_W-1:0]   RST_END_OPACITY    = OPAC_W'(100);
	localparam logic [SLIDER_W-1:0] RST_START_SLIDER   = SLIDER_W'(0);
	localparam logic [SLIDER_W-1:0] RST_END_SLIDER     = SLIDER_W'(SLIDER_RANGE);
	localparam logic [COLOR_W-1:0]  RST_LIGHT_BACKDROP = 24'hCCCCCC;
	localparam logic [COLOR_W-1:0]  RST_DARK_BACKDROP  = 24'h878787;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  entry_index;
	} req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] light_red;
		logic [CHAN_W-1:0] light_green;
		logic [CHAN_W-1:0] light_blue;
		logic [CHAN_W-1:0] dark_red;
		logic [CHAN_W-1:0] dark_green;
		logic [CHAN_W-1:0] dark_blue;
		logic              written;
	} rsp_t;

endpackage

>>> rtl/two_stop_gradient_ramp_top.sv
// two-stop gradient ramp entry lookup, pipelined top level
//
// Usage: a request on req (kind, entry_index) is taken when req_valid is high
// and req_stall is low. Each request gives exactly one response on rsp, taken
// when rsp_valid is high and rsp_stall is low: the ramp entry blended over the
// light and the dark backdrop, plus the written flag (colors are zero when
// written is low). Responses come back in request order.
// Throughput is one request per cycle while req_stall is low. The seven
// stages are slider mapping and blend products, divide by one hundred and
// span check, interpolation products, and four radix-4 steps of the
// interpolation divider.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata while no
// request is in flight; it takes effect on the next request.
// Reset clears all valid bits and loads the default stops and backdrops.
// When rsp_stall is high the response holds; stages behind it keep filling
// bubbles, and req_stall rises only once every stage holds a request.
module two_stop_gradient_ramp_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  tsgr_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output tsgr_pkg::rsp_t                       rsp,
	input  logic                                 cfg_wr_en,
	input  logic [tsgr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tsgr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int unsigned CW  = tsgr_pkg::COLOR_W;
	localparam int unsigned HW  = tsgr_pkg::CHAN_W;
	localparam int unsigned AW  = tsgr_pkg::OPAC_W;
	localparam int unsigned SW  = tsgr_pkg::SLIDER_W;
	localparam int unsigned PW  = tsgr_pkg::POS_W;
	localparam int unsigned NW  = tsgr_pkg::MAP_N_W;
	localparam int unsigned BW  = tsgr_pkg::BLEND_W;
	localparam int unsigned IW  = tsgr_pkg::INTERP_W;

	// configuration registers
	logic [CW-1:0] start_color_q, end_color_q, light_backdrop_q, dark_backdrop_q;
	logic [AW-1:0] start_opacity_q, end_opacity_q;
	logic [SW-1:0] start_slider_q, end_slider_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q    <= tsgr_pkg::RST_START_COLOR;
			end_color_q      <= tsgr_pkg::RST_END_COLOR;
			start_opacity_q  <= tsgr_pkg::RST_START_OPACITY;
			end_opacity_q    <= tsgr_pkg::RST_END_OPACITY;
			start_slider_q   <= tsgr_pkg::RST_START_SLIDER;
			end_slider_q     <= tsgr_pkg::RST_END_SLIDER;
			light_backdrop_q <= tsgr_pkg::RST_LIGHT_BACKDROP;
			dark_backdrop_q  <= tsgr_pkg::RST_DARK_BACKDROP;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tsgr_pkg::REG_START_COLOR:    start_color_q    <= cfg_wdata[CW-1:0];
				tsgr_pkg::REG_END_COLOR:      end_color_q      <= cfg_wdata[CW-1:0];
				tsgr_pkg::REG_START_OPACITY:  start_opacity_q  <= cfg_wdata[AW-1:0];
				tsgr_pkg::REG_END_OPACITY:    end_opacity_q    <= cfg_wdata[AW-1:0];
				tsgr_pkg::REG_START_SLIDER:   start_slider_q   <= cfg_wdata[SW-1:0];
				tsgr_pkg::REG_END_SLIDER:     end_slider_q     <= cfg_wdata[SW-1:0];
				tsgr_pkg::REG_LIGHT_BACKDROP: light_backdrop_q <= cfg_wdata[CW-1:0];
				tsgr_pkg::REG_DARK_BACKDROP:  dark_backdrop_q  <= cfg_wdata[CW-1:0];
				default: begin
				end
			endcase
		end
	end

	// one radix-4 step of the restoring divider, quotient bits b and b-1
	function automatic logic [IW+HW-1:0] div_step2(input logic [IW-1:0] rem,
			input logic [HW-1:0] quo, input logic [PW-1:0] d, input int unsigned b);
		logic [IW:0]   r;
		logic [HW-1:0] q;
		logic [IW:0]   ds;
		r = {1'b0, rem};
		q = quo;
		for (int unsigned i = 0; i < 2; i++) begin
			ds = (IW+1)'(d) << (b - i);
			if (r >= ds) begin
				r = r - ds;
				q[$clog2(HW)'(b - i)] = 1'b1;
			end
		end
		return {r[IW-1:0], q};
	endfunction

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [7:1] adv;

	assign adv[7] = !vld_s7 || !rsp_stall;
	assign adv[6] = !vld_s6 || adv[7];
	assign adv[5] = !vld_s5 || adv[6];
	assign adv[4] = !vld_s4 || adv[5];
	assign adv[3] = !vld_s3 || adv[4];
	assign adv[2] = !vld_s2 || adv[3];
	assign adv[1] = !vld_s1 || adv[2];

	assign req_stall = !adv[1];
	assign rsp_valid = vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= req_valid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			if (adv[6]) vld_s6 <= vld_s5;
			if (adv[7]) vld_s7 <= vld_s6;
		end
	end

	// stage 1: slider mapping and blend numerators
	logic [CW-1:0]  stop_col [2];
	logic [CW-1:0]  back_col [2];
	logic [AW-1:0]  alpha    [2];
	logic [NW-1:0]  map_n1, map_n2;
	logic [31:0]    map_p1, map_p2;
	logic [BW-1:0]  bnum     [2][2][3];

	always_comb begin
		stop_col[0] = start_color_q;
		stop_col[1] = end_color_q;
		back_col[0] = light_backdrop_q;
		back_col[1] = dark_backdrop_q;
		alpha[0] = (start_opacity_q > tsgr_pkg::OPACITY_FULL) ?
			tsgr_pkg::OPACITY_FULL : start_opacity_q;
		alpha[1] = (end_opacity_q > tsgr_pkg::OPACITY_FULL) ?
			tsgr_pkg::OPACITY_FULL : end_opacity_q;
		map_n1 = NW'(start_slider_q) * NW'(tsgr_pkg::RAMP_LENGTH);
		map_n2 = NW'(end_slider_q) * NW'(tsgr_pkg::RAMP_LENGTH);
		map_p1 = 32'(map_n1) * 32'(tsgr_pkg::MAP_MUL);
		map_p2 = 32'(map_n2) * 32'(tsgr_pkg::MAP_MUL);
		for (int s = 0; s < 2; s++) begin
			for (int b = 0; b < 2; b++) begin
				for (int k = 0; k < 3; k++) begin
					bnum[s][b][k] =
						BW'(stop_col[s][CW-1-HW*k -: HW]) * BW'(alpha[s]) +
						BW'(back_col[b][CW-1-HW*k -: HW]) *
						BW'(tsgr_pkg::OPACITY_FULL - alpha[s]);
				end
			end
		end
	end

	tsgr_pkg::req_t req_s1;
	logic [PW-1:0]  p1_s1, p2_s1;
	logic [BW-1:0]  bnum_s1 [2][2][3];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			req_s1  <= req;
			p1_s1   <= PW'(map_p1 >> tsgr_pkg::MAP_SHIFT);
			p2_s1   <= PW'(map_p2 >> tsgr_pkg::MAP_SHIFT);
			bnum_s1 <= bnum;
		end
	end

	// stage 2: divide by one hundred, span check
	logic [31:0]   bprod [2][2][3];
	logic [PW-1:0] lo, hi, dv, ix, jj;
	logic          span_ok;

	always_comb begin
		for (int s = 0; s < 2; s++) begin
			for (int b = 0; b < 2; b++) begin
				for (int k = 0; k < 3; k++) begin
					bprod[s][b][k] = 32'(bnum_s1[s][b][k]) * 32'(tsgr_pkg::DIV100_MUL);
				end
			end
		end
		ix = PW'(req_s1.entry_index);
		if (req_s1.kind) begin
			lo = p1_s1 >> 1;
			hi = p2_s1 >> 1;
			dv = (p2_s1 - p1_s1) >> 1;
		end else begin
			lo = p1_s1;
			hi = p2_s1;
			dv = p2_s1 - p1_s1;
		end
		span_ok = ({1'b0, p2_s1} > ({1'b0, p1_s1} + 1'b1)) && (ix >= lo) && (ix < hi) &&
			(32'(req_s1.entry_index) < tsgr_pkg::RAMP_LENGTH) && (dv != '0);
		jj = ix - lo;
	end

	logic          ok_s2;
	logic [PW-1:0] div_s2, j_s2;
	logic [HW-1:0] bl_s2 [2][2][3];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			ok_s2  <= span_ok;
			div_s2 <= dv;
			j_s2   <= (jj > dv) ? dv : jj;
			for (int s = 0; s < 2; s++) begin
				for (int b = 0; b < 2; b++) begin
					for (int k = 0; k < 3; k++) begin
						bl_s2[s][b][k] <= HW'(bprod[s][b][k] >> tsgr_pkg::DIV100_SHIFT);
					end
				end
			end
		end
	end

	// stage 3: interpolation numerators
	logic          ok_s3;
	logic [PW-1:0] div_s3;
	logic [IW-1:0] num_s3 [2][3];

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			ok_s3  <= ok_s2;
			div_s3 <= div_s2;
			for (int b = 0; b < 2; b++) begin
				for (int k = 0; k < 3; k++) begin
					num_s3[b][k] <= IW'(bl_s2[0][b][k]) * IW'(div_s2 - j_s2) +
						IW'(bl_s2[1][b][k]) * IW'(j_s2);
				end
			end
		end
	end

	// stages 4 to 7: radix-4 restoring divider
	logic          ok_s4, ok_s5, ok_s6;
	logic [PW-1:0] div_s4, div_s5, div_s6;
	logic [IW-1:0] rem_s4 [2][3];
	logic [IW-1:0] rem_s5 [2][3];
	logic [IW-1:0] rem_s6 [2][3];
	logic [HW-1:0] quo_s4 [2][3];
	logic [HW-1:0] quo_s5 [2][3];
	logic [HW-1:0] quo_s6 [2][3];
	logic [HW-1:0] quo_fin [2][3];
	tsgr_pkg::rsp_t rsp_s7;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			ok_s4  <= ok_s3;
			div_s4 <= div_s3;
			for (int b = 0; b < 2; b++) begin
				for (int k = 0; k < 3; k++) begin
					{rem_s4[b][k], quo_s4[b][k]} <= div_step2(num_s3[b][k], '0, div_s3, HW - 1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			ok_s5  <= ok_s4;
			div_s5 <= div_s4;
			for (int b = 0; b < 2; b++) begin
				for (int k = 0; k < 3; k++) begin
					{rem_s5[b][k], quo_s5[b][k]} <=
						div_step2(rem_s4[b][k], quo_s4[b][k], div_s4, HW - 3);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			ok_s6  <= ok_s5;
			div_s6 <= div_s5;
			for (int b = 0; b < 2; b++) begin
				for (int k = 0; k < 3; k++) begin
					{rem_s6[b][k], quo_s6[b][k]} <=
						div_step2(rem_s5[b][k], quo_s5[b][k], div_s5, HW - 5);
				end
			end
		end
	end

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			for (int k = 0; k < 3; k++) begin
				quo_fin[b][k] = HW'(div_step2(rem_s6[b][k], quo_s6[b][k], div_s6, HW - 7)) &
					{HW{ok_s6}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			rsp_s7.light_red   <= quo_fin[0][0];
			rsp_s7.light_green <= quo_fin[0][1];
			rsp_s7.light_blue  <= quo_fin[0][2];
			rsp_s7.dark_red    <= quo_fin[1][0];
			rsp_s7.dark_green  <= quo_fin[1][1];
			rsp_s7.dark_blue   <= quo_fin[1][2];
			rsp_s7.written     <= ok_s6;
		end
	end

	assign rsp = rsp_s7;

endmodule

>>> rtl/tsgr_checker.sv
// port-level checker for the gradient ramp top level, with its bind
module tsgr_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic                              req_stall,
	input  tsgr_pkg::req_t                    req,
	input  logic                              rsp_valid,
	input  logic                              rsp_stall,
	input  tsgr_pkg::rsp_t                    rsp
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request changed while stalled");

	// entry outside the span reads as black
	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.written |-> rsp.light_red == '0 && rsp.light_green == '0 &&
			rsp.light_blue == '0 && rsp.dark_red == '0 && rsp.dark_green == '0 &&
			rsp.dark_blue == '0)
		else $error("unwritten entry carries color");

	// request side backs up only behind a stalled full pipe
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled while output can move");

endmodule

bind two_stop_gradient_ramp_top tsgr_checker u_tsgr_checker (.*);

>>> sim/tb.sv
// testbench for the two-stop gradient ramp lookup with a self-checking predictor
module tb;

	localparam logic KIND_LINEAR = 1'b0;
	localparam logic KIND_RADIAL = 1'b1;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned REPORT_LIMIT = 40;
	localparam int unsigned RANDOM_PHASES = 25;
	localparam int unsigned REQS_PER_PHASE = 50;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct packed {
		logic [tsgr_pkg::COLOR_W-1:0]  start_color;
		logic [tsgr_pkg::COLOR_W-1:0]  end_color;
		logic [tsgr_pkg::OPAC_W-1:0]   start_opacity;
		logic [tsgr_pkg::OPAC_W-1:0]   end_opacity;
		logic [tsgr_pkg::SLIDER_W-1:0] start_slider;
		logic [tsgr_pkg::SLIDER_W-1:0] end_slider;
		logic [tsgr_pkg::COLOR_W-1:0]  light_backdrop;
		logic [tsgr_pkg::COLOR_W-1:0]  dark_backdrop;
	} ramp_cfg_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            req_valid = 1'b0;
	logic                            req_stall;
	tsgr_pkg::req_t                  req = '0;
	logic                            rsp_valid;
	logic                            rsp_stall = 1'b0;
	tsgr_pkg::rsp_t                  rsp;
	logic                            cfg_wr_en = 1'b0;
	logic [tsgr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tsgr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	ramp_cfg_t      ramp_cfg;
	tsgr_pkg::rsp_t expected_entries [$];
	int unsigned    mismatch_count = 0;
	int unsigned    burst_left = 0;
	int unsigned    quiet_cycles = 0;
	int unsigned    stall_count = 0;
	stall_mode_t    stall_mode = STALL_NONE;

	two_stop_gradient_ramp_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned stop_position(
			input logic [tsgr_pkg::SLIDER_W-1:0] slider);
		return (32'(slider) * tsgr_pkg::RAMP_LENGTH) / tsgr_pkg::SLIDER_RANGE;
	endfunction

	function automatic tsgr_pkg::rsp_t ramp_entry(input tsgr_pkg::req_t r,
			input ramp_cfg_t c);
		int unsigned p1, p2, a1, a2, lo, hi, span, j, sh, idx, full;
		int unsigned s1, s2, bl, bd, l1, l2, d1, d2;
		int unsigned light [3];
		int unsigned dark [3];
		bit ok;
		tsgr_pkg::rsp_t e;
		full = 32'(tsgr_pkg::OPACITY_FULL);
		idx = 32'(r.entry_index);
		p1 = stop_position(c.start_slider);
		p2 = stop_position(c.end_slider);
		a1 = 32'((c.start_opacity > tsgr_pkg::OPACITY_FULL) ?
			tsgr_pkg::OPACITY_FULL : c.start_opacity);
		a2 = 32'((c.end_opacity > tsgr_pkg::OPACITY_FULL) ?
			tsgr_pkg::OPACITY_FULL : c.end_opacity);
		ok = 1'b0;
		span = 0;
		j = 0;
		if (p2 > p1 + 1) begin
			lo = (r.kind == KIND_RADIAL) ? p1 / 2 : p1;
			hi = (r.kind == KIND_RADIAL) ? p2 / 2 : p2;
			span = (r.kind == KIND_RADIAL) ? (p2 - p1) / 2 : p2 - p1;
			if (idx >= lo && idx < hi && idx < tsgr_pkg::RAMP_LENGTH && span != 0) begin
				ok = 1'b1;
				j = idx - lo;
				if (j > span)
					j = span;
			end
		end
		for (int k = 0; k < 3; k++) begin
			light[k] = 0;
			dark[k] = 0;
			if (ok) begin
				sh = 32'(16 - 8 * k);
				s1 = (32'(c.start_color) >> sh) & 32'hFF;
				s2 = (32'(c.end_color) >> sh) & 32'hFF;
				bl = (32'(c.light_backdrop) >> sh) & 32'hFF;
				bd = (32'(c.dark_backdrop) >> sh) & 32'hFF;
				l1 = (s1 * a1 + bl * (full - a1)) / full;
				l2 = (s2 * a2 + bl * (full - a2)) / full;
				d1 = (s1 * a1 + bd * (full - a1)) / full;
				d2 = (s2 * a2 + bd * (full - a2)) / full;
				light[k] = (l1 * (span - j) + l2 * j) / span;
				dark[k] = (d1 * (span - j) + d2 * j) / span;
			end
		end
		e.light_red = tsgr_pkg::CHAN_W'(light[0]);
		e.light_green = tsgr_pkg::CHAN_W'(light[1]);
		e.light_blue = tsgr_pkg::CHAN_W'(light[2]);
		e.dark_red = tsgr_pkg::CHAN_W'(dark[0]);
		e.dark_green = tsgr_pkg::CHAN_W'(dark[1]);
		e.dark_blue = tsgr_pkg::CHAN_W'(dark[2]);
		e.written = ok;
		return e;
	endfunction

	// sender: bursts of requests with random gaps between them
	task automatic send_req(input logic kind, input logic [tsgr_pkg::IDX_W-1:0] idx);
		tsgr_pkg::req_t r;
		r.kind = kind;
		r.entry_index = idx;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected_entries.push_back(ramp_entry(r, ramp_cfg));
		burst_left--;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tsgr_pkg::CFG_IDX_W-1:0] idx,
			input logic [tsgr_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic apply_config(input ramp_cfg_t c);
		drain();
		write_reg(tsgr_pkg::REG_START_COLOR, c.start_color);
		write_reg(tsgr_pkg::REG_END_COLOR, c.end_color);
		write_reg(tsgr_pkg::REG_START_OPACITY, tsgr_pkg::CFG_DATA_W'(c.start_opacity));
		write_reg(tsgr_pkg::REG_END_OPACITY, tsgr_pkg::CFG_DATA_W'(c.end_opacity));
		write_reg(tsgr_pkg::REG_START_SLIDER, tsgr_pkg::CFG_DATA_W'(c.start_slider));
		write_reg(tsgr_pkg::REG_END_SLIDER, tsgr_pkg::CFG_DATA_W'(c.end_slider));
		write_reg(tsgr_pkg::REG_LIGHT_BACKDROP, c.light_backdrop);
		write_reg(tsgr_pkg::REG_DARK_BACKDROP, c.dark_backdrop);
		cfg_wr_en <= 1'b0;
		ramp_cfg = c;
		@(posedge clk);
	endtask

	task automatic test_default_ramp();
		send_req(KIND_LINEAR, 6'd0);
		send_req(KIND_LINEAR, 6'd43);
		send_req(KIND_LINEAR, 6'd44);
		send_req(KIND_LINEAR, 6'd63);
		send_req(KIND_RADIAL, 6'd0);
		send_req(KIND_RADIAL, 6'd21);
		send_req(KIND_RADIAL, 6'd22);
	endtask

	task automatic test_stop_extremes();
		ramp_cfg_t c;
		// saturated and zero opacity, slider past its range
		c.start_color = 24'h000000;
		c.end_color = 24'hFFFFFF;
		c.start_opacity = 7'd127;
		c.end_opacity = 7'd0;
		c.start_slider = 8'd0;
		c.end_slider = 8'd255;
		c.light_backdrop = 24'hFFFFFF;
		c.dark_backdrop = 24'h000000;
		apply_config(c);
		send_req(KIND_LINEAR, 6'd0);
		send_req(KIND_LINEAR, 6'd43);
		send_req(KIND_LINEAR, 6'd44);
		send_req(KIND_RADIAL, 6'd32);
		send_req(KIND_RADIAL, 6'd33);
		// reversed stops
		c.start_slider = 8'd168;
		c.end_slider = 8'd0;
		apply_config(c);
		send_req(KIND_LINEAR, 6'd0);
		send_req(KIND_RADIAL, 6'd0);
		// shortest span that is written
		c.start_slider = 8'd0;
		c.end_slider = 8'd8;
		c.start_opacity = 7'd100;
		c.end_opacity = 7'd100;
		apply_config(c);
		send_req(KIND_LINEAR, 6'd0);
		send_req(KIND_LINEAR, 6'd1);
		send_req(KIND_LINEAR, 6'd2);
		send_req(KIND_RADIAL, 6'd0);
		send_req(KIND_RADIAL, 6'd1);
		// span of one is never written
		c.end_slider = 8'd4;
		apply_config(c);
		send_req(KIND_LINEAR, 6'd0);
	endtask

	function automatic logic [tsgr_pkg::SLIDER_W-1:0] random_slider();
		case ($urandom_range(0, 7))
			0: return tsgr_pkg::SLIDER_W'($urandom_range(tsgr_pkg::SLIDER_RANGE + 1,
				2**tsgr_pkg::SLIDER_W - 1));
			1: return '0;
			2: return tsgr_pkg::SLIDER_W'(tsgr_pkg::SLIDER_RANGE);
			default: return tsgr_pkg::SLIDER_W'($urandom_range(0, tsgr_pkg::SLIDER_RANGE));
		endcase
	endfunction

	function automatic logic [tsgr_pkg::OPAC_W-1:0] random_opacity();
		case ($urandom_range(0, 7))
			0: return tsgr_pkg::OPAC_W'($urandom_range(32'(tsgr_pkg::OPACITY_FULL) + 1,
				2**tsgr_pkg::OPAC_W - 1));
			1: return '0;
			2: return tsgr_pkg::OPACITY_FULL;
			default: return tsgr_pkg::OPAC_W'($urandom_range(0,
				32'(tsgr_pkg::OPACITY_FULL)));
		endcase
	endfunction

	function automatic logic [tsgr_pkg::COLOR_W-1:0] random_color();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return tsgr_pkg::COLOR_W'($urandom());
		endcase
	endfunction

	task automatic test_random_ramps();
		ramp_cfg_t c;
		logic [tsgr_pkg::SLIDER_W-1:0] swap;
		logic kind;
		int unsigned lo, hi;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			c.start_color = random_color();
			c.end_color = random_color();
			c.start_opacity = random_opacity();
			c.end_opacity = random_opacity();
			c.start_slider = random_slider();
			c.end_slider = random_slider();
			c.light_backdrop = random_color();
			c.dark_backdrop = random_color();
			// mostly ordered stops so that entries get written
			if ($urandom_range(0, 3) != 0 && c.start_slider > c.end_slider) begin
				swap = c.start_slider;
				c.start_slider = c.end_slider;
				c.end_slider = swap;
			end
			apply_config(c);
			for (int n = 0; n < REQS_PER_PHASE; n++) begin
				kind = 1'($urandom_range(0, 1));
				lo = stop_position(c.start_slider);
				hi = stop_position(c.end_slider);
				if (kind == KIND_RADIAL) begin
					lo = lo / 2;
					hi = hi / 2;
				end
				if ($urandom_range(0, 3) == 0)
					send_req(kind, tsgr_pkg::IDX_W'($urandom_range(0,
						2**tsgr_pkg::IDX_W - 1)));
				else
					send_req(kind, tsgr_pkg::IDX_W'($urandom_range(lo > 0 ? lo - 1 : 0,
						hi < 2**tsgr_pkg::IDX_W - 1 ? hi : 2**tsgr_pkg::IDX_W - 1)));
			end
		end
	endtask

	initial begin
		ramp_cfg.start_color = tsgr_pkg::RST_START_COLOR;
		ramp_cfg.end_color = tsgr_pkg::RST_END_COLOR;
		ramp_cfg.start_opacity = tsgr_pkg::RST_START_OPACITY;
		ramp_cfg.end_opacity = tsgr_pkg::RST_END_OPACITY;
		ramp_cfg.start_slider = tsgr_pkg::RST_START_SLIDER;
		ramp_cfg.end_slider = tsgr_pkg::RST_END_SLIDER;
		ramp_cfg.light_backdrop = tsgr_pkg::RST_LIGHT_BACKDROP;
		ramp_cfg.dark_backdrop = tsgr_pkg::RST_DARK_BACKDROP;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_ramp();
		test_stop_extremes();
		test_random_ramps();
		drain();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// receiver stall pattern, changing mode every so often
	always @(posedge clk) begin
		if (stall_count == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_count <= $urandom_range(50, 200);
		end else begin
			stall_count <= stall_count - 1;
		end
		case (stall_mode)
			STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: rsp_stall <= (stall_count % 7 < 3);
			default: rsp_stall <= 1'b0;
		endcase
	end

	task automatic check_field(input string name, input logic [tsgr_pkg::CHAN_W-1:0] exp,
			input logic [tsgr_pkg::CHAN_W-1:0] act);
		if (act !== exp) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
		end
	endtask

	always @(posedge clk) begin
		tsgr_pkg::rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_entries.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: response expected none, got %h", $time, rsp);
			end else begin
				e = expected_entries.pop_front();
				check_field("light_red", e.light_red, rsp.light_red);
				check_field("light_green", e.light_green, rsp.light_green);
				check_field("light_blue", e.light_blue, rsp.light_blue);
				check_field("dark_red", e.dark_red, rsp.dark_red);
				check_field("dark_green", e.dark_green, rsp.dark_green);
				check_field("dark_blue", e.dark_blue, rsp.dark_blue);
				check_field("written", tsgr_pkg::CHAN_W'(e.written),
					tsgr_pkg::CHAN_W'(rsp.written));
			end
		end
	end

	// watchdog on cycles with no request or response taken
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

>>> filelist.f
rtl/tsgr_pkg.sv
rtl/two_stop_gradient_ramp_top.sv
rtl/tsgr_checker.sv
sim/tb.sv
